[rtl/ptc_pkg.sv]
// Shared types and constants for the pressure/temperature compensation core.
// No dependencies; used by every module under rtl/.
package ptc_pkg;

  // Divider steps: one quotient bit per stage over the 64-bit numerator.
  localparam int DIV_STEPS = 64;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TEMP_COEFFS = 2'd0;
  localparam cfg_idx_t CFG_PRESS_LOW   = 2'd1;
  localparam cfg_idx_t CFG_PRESS_HIGH  = 2'd2;
  localparam cfg_idx_t CFG_PRESS_NINE  = 2'd3;

  localparam logic signed [32:0] FINE_OFFSET  = 33'sd128000;
  localparam logic [20:0]        PRESS_FULL   = 21'd1048576;
  localparam logic [63:0]        PRESS_SCALE  = 64'd3125;
  localparam logic [34:0]        TEMP_ROUND   = 35'd128;
  localparam logic [63:0]        PRESS_BIAS47 = 64'h0000_8000_0000_0000;

  // Calibration coefficients, all 16 bits; t1 and p1 unsigned, others signed.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  // Temperature results that ride along with the pressure computation.
  typedef struct packed {
    logic [26:0] temp;
    logic [31:0] fine;
  } side_t;

endpackage

[rtl/ptc_temp.sv]
// Temperature stages: fine temperature with 32-bit wrap and centidegree output.
// Three register stages; depends on ptc_pkg.
module ptc_temp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [19:0]       raw_t,
  input  logic [19:0]       raw_p,
  input  ptc_pkg::coef_t    coef,
  output logic              vld,
  output ptc_pkg::side_t    side,
  output logic [19:0]       raw_p_o
);

  logic signed [17:0] a;
  logic signed [16:0] b;
  logic signed [33:0] at_full;
  logic signed [33:0] bb_full;
  logic signed [31:0] v1;
  logic signed [31:0] bbs;
  logic signed [35:0] m_full;
  logic signed [31:0] v2;
  logic [31:0]        fine;
  logic [34:0]        f35;
  logic [34:0]        t35;

  logic        s1_vld_r, s2_vld_r, s3_vld_r;
  logic [31:0] at_r, bb_r;
  logic [31:0] tv1_r, m_r;
  logic [19:0] rp1_r, rp2_r, rp3_r;
  ptc_pkg::side_t side_r;

  always_comb begin
    a       = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    b       = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
    at_full = a * $signed(coef.t2);
    bb_full = b * b;
    v1      = $signed(at_r) >>> 11;
    bbs     = $signed(bb_r) >>> 12;
    m_full  = $signed(bbs[19:0]) * $signed(coef.t3);
    v2      = $signed(m_r) >>> 14;
    fine    = tv1_r + v2;
    f35     = {{3{fine[31]}}, fine};
    t35     = (f35 << 2) + f35 + ptc_pkg::TEMP_ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at_r        <= at_full[31:0];
      bb_r        <= bb_full[31:0];
      rp1_r       <= raw_p;
      tv1_r       <= v1;
      m_r         <= m_full[31:0];
      rp2_r       <= rp1_r;
      side_r.fine <= fine;
      side_r.temp <= t35[34:8];
      rp3_r       <= rp2_r;
    end
  end

  assign vld     = s3_vld_r;
  assign side    = side_r;
  assign raw_p_o = rp3_r;

endmodule

[rtl/ptc_press_pre.sv]
// Pressure stages ahead of the divider: offsets, numerator and divisor forms.
// Six register stages; depends on ptc_pkg.
module ptc_press_pre (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  ptc_pkg::side_t    in_side,
  input  logic [19:0]       raw_p,
  input  ptc_pkg::coef_t    coef,
  output logic              vld,
  output ptc_pkg::side_t    side,
  output logic              pok,
  output logic              neg,
  output logic [63:0]       num_mag,
  output logic [31:0]       den_mag
);

  logic signed [32:0] x1;
  logic signed [65:0] sq_full;
  logic signed [48:0] x5_full, x2_full;
  logic [63:0]        sq6, sq3, t5, t2;
  logic signed [63:0] sq3_sh;
  logic [63:0]        x2n, x1a, x1b;
  logic [20:0]        pd;
  logic [63:0]        pn;
  logic signed [63:0] dsh;
  logic [63:0]        nsc;

  logic [5:0]  vld_r;
  ptc_pkg::side_t side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  logic [19:0] rp1_r, rp2_r, rp3_r;
  logic [63:0] sq_r;
  logic [48:0] x5_r, x2_r;
  logic [63:0] sq6_r, sq3_r, t5_r, t2_r;
  logic [63:0] x2n_r, x1a_r;
  logic [63:0] x1b_r, pn_r;
  logic [31:0] d_r;
  logic [63:0] n_r;
  logic        pok5_r, pok6_r, neg6_r;
  logic [63:0] an_r;
  logic [31:0] ad_r;

  always_comb begin
    x1      = $signed({in_side.fine[31], in_side.fine}) - ptc_pkg::FINE_OFFSET;
    sq_full = x1 * x1;
    x5_full = x1 * $signed(coef.p5);
    x2_full = x1 * $signed(coef.p2);
    sq6     = $signed(sq_r) * $signed(coef.p6);
    sq3     = $signed(sq_r) * $signed(coef.p3);
    t5      = {{15{x5_r[48]}}, x5_r} << 17;
    t2      = {{15{x2_r[48]}}, x2_r} << 12;
    sq3_sh  = $signed(sq3_r) >>> 8;
    x2n     = sq6_r + t5_r + {{13{coef.p4[15]}}, coef.p4, 35'b0};
    x1a     = sq3_sh + t2_r;
    x1b     = (x1a_r + ptc_pkg::PRESS_BIAS47) * {48'b0, coef.p1};
    pd      = ptc_pkg::PRESS_FULL - {1'b0, rp3_r};
    pn      = {12'b0, pd, 31'b0} - x2n_r;
    dsh     = $signed(x1b_r) >>> 33;
    nsc     = pn_r * ptc_pkg::PRESS_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: squares and linear products of the offset fine temperature
      side1_r <= in_side;
      rp1_r   <= raw_p;
      sq_r    <= sq_full[63:0];
      x5_r    <= x5_full;
      x2_r    <= x2_full;
      // stage 2
      side2_r <= side1_r;
      rp2_r   <= rp1_r;
      sq6_r   <= sq6;
      sq3_r   <= sq3;
      t5_r    <= t5;
      t2_r    <= t2;
      // stage 3
      side3_r <= side2_r;
      rp3_r   <= rp2_r;
      x2n_r   <= x2n;
      x1a_r   <= x1a;
      // stage 4
      side4_r <= side3_r;
      x1b_r   <= x1b;
      pn_r    <= pn;
      // stage 5: divisor and scaled numerator
      side5_r <= side4_r;
      d_r     <= dsh[31:0];
      n_r     <= nsc;
      pok5_r  <= (side4_r.fine != 32'd0) && (dsh != 64'sd0);
      // stage 6: magnitudes and quotient sign
      side6_r <= side5_r;
      pok6_r  <= pok5_r;
      neg6_r  <= n_r[63] ^ d_r[31];
      an_r    <= n_r[63] ? (64'd0 - n_r) : n_r;
      ad_r    <= d_r[31] ? (32'd0 - d_r) : d_r;
    end
  end

  assign vld     = vld_r[5];
  assign side    = side6_r;
  assign pok     = pok6_r;
  assign neg     = neg6_r;
  assign num_mag = an_r;
  assign den_mag = ad_r;

endmodule

[rtl/ptc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Divisor magnitude is at most 2^31; depends on ptc_pkg.
module ptc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  ptc_pkg::side_t    in_side,
  input  logic              in_pok,
  input  logic              in_neg,
  input  logic [63:0]       num_mag,
  input  logic [31:0]       den_mag,
  output logic              vld,
  output ptc_pkg::side_t    side,
  output logic              pok,
  output logic              neg,
  output logic [63:0]       quot
);

  localparam int N = ptc_pkg::DIV_STEPS;

  logic [63:0]    nq_r   [N];
  logic [31:0]    rem_r  [N];
  logic [31:0]    den_r  [N];
  ptc_pkg::side_t side_r [N];
  logic [N-1:0]   pok_r, neg_r, vld_r;

  logic [63:0]    nq_nxt  [N];
  logic [31:0]    rem_nxt [N];

  always_comb begin
    logic [63:0] nq_in;
    logic [31:0] rem_in;
    logic [31:0] den_in;
    logic [31:0] trial;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      nq_in  = (k == 0) ? num_mag : nq_r[(k == 0) ? 0 : k - 1];
      rem_in = (k == 0) ? 32'd0   : rem_r[(k == 0) ? 0 : k - 1];
      den_in = (k == 0) ? den_mag : den_r[(k == 0) ? 0 : k - 1];
      // shift in the next numerator bit, subtract when it fits
      trial  = {rem_in[30:0], nq_in[63]};
      ge     = (trial >= den_in);
      rem_nxt[k] = ge ? (trial - den_in) : trial;
      nq_nxt[k]  = {nq_in[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        nq_r[k]  <= nq_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
      den_r[0]  <= den_mag;
      side_r[0] <= in_side;
      for (int k = 1; k < N; k++) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      pok_r <= {pok_r[N-2:0], in_pok};
      neg_r <= {neg_r[N-2:0], in_neg};
    end
  end

  assign vld  = vld_r[N-1];
  assign side = side_r[N-1];
  assign pok  = pok_r[N-1];
  assign neg  = neg_r[N-1];
  assign quot = nq_r[N-1];

endmodule

[rtl/ptc_press_post.sv]
// Pressure stages after the divider: second-order corrections and Q24.8 result.
// Six register stages, the last being the output register; depends on ptc_pkg.
module ptc_press_post (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  ptc_pkg::side_t    in_side,
  input  logic              in_pok,
  input  logic              in_neg,
  input  logic [63:0]       quot,
  input  ptc_pkg::coef_t    coef,
  output logic              vld,
  output ptc_pkg::side_t    side,
  output logic [31:0]       pres,
  output logic              pres_ok
);

  logic signed [63:0] ps;
  logic [63:0]        ll;
  logic [31:0]        cr;
  logic [63:0]        y2raw;
  logic signed [63:0] y2;
  logic [63:0]        y1raw;
  logic signed [63:0] y1;
  logic [63:0]        sum;
  logic signed [63:0] ssh;
  logic [31:0]        res;

  logic [5:0]  vld_r;
  ptc_pkg::side_t side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  logic        pok1_r, pok2_r, pok3_r, pok4_r, pok5_r, pok6_r;
  logic [63:0] p1_r, p2_r, p3_r, p4_r;
  logic [63:0] ll_r, y2raw_r;
  logic [31:0] cr_r;
  logic [63:0] pssq_r, y2_r, y2b_r;
  logic [63:0] y1raw_r;
  logic [63:0] sum_r;
  logic [31:0] pres_r;

  always_comb begin
    ps    = $signed(p1_r) >>> 13;
    ll    = ps[31:0] * ps[31:0];
    cr    = ps[31:0] * ps[63:32];
    y2raw = $signed(p1_r) * $signed(coef.p8);
    y2    = $signed(y2raw_r) >>> 19;
    y1raw = $signed(pssq_r) * $signed(coef.p9);
    y1    = $signed(y1raw_r) >>> 25;
    sum   = p4_r + y1 + y2b_r;
    ssh   = $signed(sum_r) >>> 8;
    res   = ssh[31:0] + {{12{coef.p7[15]}}, coef.p7, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: restore quotient sign
      side1_r <= in_side;
      pok1_r  <= in_pok;
      p1_r    <= in_neg ? (64'd0 - quot) : quot;
      // stage 2: square of the scaled pressure as 32-bit partial products
      side2_r <= side1_r;
      pok2_r  <= pok1_r;
      p2_r    <= p1_r;
      ll_r    <= ll;
      cr_r    <= cr;
      y2raw_r <= y2raw;
      // stage 3
      side3_r <= side2_r;
      pok3_r  <= pok2_r;
      p3_r    <= p2_r;
      pssq_r  <= ll_r + {cr_r[30:0], 33'b0};
      y2_r    <= y2;
      // stage 4
      side4_r <= side3_r;
      pok4_r  <= pok3_r;
      p4_r    <= p3_r;
      y1raw_r <= y1raw;
      y2b_r   <= y2_r;
      // stage 5
      side5_r <= side4_r;
      pok5_r  <= pok4_r;
      sum_r   <= sum;
      // stage 6: output register, drop the pressure when not computed
      side6_r <= side5_r;
      pok6_r  <= pok5_r;
      pres_r  <= pok5_r ? res : 32'd0;
    end
  end

  assign vld     = vld_r[5];
  assign side    = side6_r;
  assign pres    = pres_r;
  assign pres_ok = pok6_r;

endmodule

[rtl/pressure_temperature_compensation_core.sv]
// Pressure/temperature compensation core, fully pipelined.
// Stages from an accepted input transaction to its result: 3 temperature,
// 6 pre-divide, 64 divider and 6 post-divide register stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// valid output is stalled. Synchronous active-low reset clears valid bits and
// calibration registers to zero.
module pressure_temperature_compensation_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [19:0]         in_raw_temperature,
  input  logic [19:0]         in_raw_pressure,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [26:0]  out_temperature_centi,
  output logic signed [31:0]  out_fine_temperature,
  output logic [31:0]         out_pressure_q24_8,
  output logic                out_pressure_valid,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ptc_pkg::cfg_idx_t   cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_nine_r;

  ptc_pkg::coef_t coef;
  logic           en;

  logic           t_vld;
  ptc_pkg::side_t t_side;
  logic [19:0]    t_raw_p;

  logic           pre_vld, pre_pok, pre_neg;
  ptc_pkg::side_t pre_side;
  logic [63:0]    pre_num;
  logic [31:0]    pre_den;

  logic           d_vld, d_pok, d_neg;
  ptc_pkg::side_t d_side;
  logic [63:0]    d_quot;

  logic           o_vld;
  ptc_pkg::side_t o_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r   <= '0;
      press_high_r  <= '0;
      press_nine_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptc_pkg::CFG_TEMP_COEFFS: temp_coeffs_r <= cfg_data[47:0];
        ptc_pkg::CFG_PRESS_LOW:   press_low_r   <= cfg_data;
        ptc_pkg::CFG_PRESS_HIGH:  press_high_r  <= cfg_data;
        ptc_pkg::CFG_PRESS_NINE:  press_nine_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_coeffs_r[15:0];
    coef.t2 = temp_coeffs_r[31:16];
    coef.t3 = temp_coeffs_r[47:32];
    coef.p1 = press_low_r[15:0];
    coef.p2 = press_low_r[31:16];
    coef.p3 = press_low_r[47:32];
    coef.p4 = press_low_r[63:48];
    coef.p5 = press_high_r[15:0];
    coef.p6 = press_high_r[31:16];
    coef.p7 = press_high_r[47:32];
    coef.p8 = press_high_r[63:48];
    coef.p9 = press_nine_r;
  end

  // advance every stage unless a finished result is held by the consumer
  assign en       = !(o_vld && out_stall);
  assign in_stall = !en;

  ptc_temp u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .raw_t   (in_raw_temperature),
    .raw_p   (in_raw_pressure),
    .coef    (coef),
    .vld     (t_vld),
    .side    (t_side),
    .raw_p_o (t_raw_p)
  );

  ptc_press_pre u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (t_vld),
    .in_side (t_side),
    .raw_p   (t_raw_p),
    .coef    (coef),
    .vld     (pre_vld),
    .side    (pre_side),
    .pok     (pre_pok),
    .neg     (pre_neg),
    .num_mag (pre_num),
    .den_mag (pre_den)
  );

  ptc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pre_vld),
    .in_side (pre_side),
    .in_pok  (pre_pok),
    .in_neg  (pre_neg),
    .num_mag (pre_num),
    .den_mag (pre_den),
    .vld     (d_vld),
    .side    (d_side),
    .pok     (d_pok),
    .neg     (d_neg),
    .quot    (d_quot)
  );

  ptc_press_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld),
    .in_side (d_side),
    .in_pok  (d_pok),
    .in_neg  (d_neg),
    .quot    (d_quot),
    .coef    (coef),
    .vld     (o_vld),
    .side    (o_side),
    .pres    (out_pressure_q24_8),
    .pres_ok (out_pressure_valid)
  );

  assign out_valid             = o_vld;
  assign out_temperature_centi = $signed(o_side.temp);
  assign out_fine_temperature  = $signed(o_side.fine);

endmodule

[bench/tb_pressure_temperature_compensation_core.sv]
// Self-checking bench for pressure_temperature_compensation_core.
// Holds a compensation predictor in a small scoreboard class and drives the input
// and output channels with random idles; depends on rtl/ptc_pkg.sv and the core.
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_core;

  typedef struct packed {
    logic signed [26:0] temp_centi;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               press_ok;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0] temp_word;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] p9_word;
    comp_result_t pending[$];
    int errors;

    function new();
      temp_word = '0;
      press_lo = '0;
      press_hi = '0;
      p9_word = '0;
      errors = 0;
    endfunction

    function void set_reg(ptc_pkg::cfg_idx_t idx, logic [63:0] data);
      case (idx)
        ptc_pkg::CFG_TEMP_COEFFS: temp_word = data[47:0];
        ptc_pkg::CFG_PRESS_LOW:   press_lo = data;
        ptc_pkg::CFG_PRESS_HIGH:  press_hi = data;
        ptc_pkg::CFG_PRESS_NINE:  p9_word = data[15:0];
        default: ;
      endcase
    endfunction

    function automatic logic signed [63:0] sdiv(logic signed [63:0] n,
                                                logic signed [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function void note_sample(logic [19:0] raw_t, logic [19:0] raw_p);
      comp_result_t r;
      logic signed [31:0] t1, t2, t3, a, b, v1, v2, fine;
      logic signed [63:0] f64, tmp, x1, x2, p, ps, y1, y2;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      t1 = {16'd0, temp_word[15:0]};
      t2 = {{16{temp_word[31]}}, temp_word[31:16]};
      t3 = {{16{temp_word[47]}}, temp_word[47:32]};
      a = {15'd0, raw_t[19:3]} - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      b = {16'd0, raw_t[19:4]} - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      fine = v1 + v2;
      f64 = fine;
      tmp = (f64 * 5 + 128) >>> 8;
      p1 = {48'd0, press_lo[15:0]};
      p2 = $signed(press_lo[31:16]);
      p3 = $signed(press_lo[47:32]);
      p4 = $signed(press_lo[63:48]);
      p5 = $signed(press_hi[15:0]);
      p6 = $signed(press_hi[31:16]);
      p7 = $signed(press_hi[47:32]);
      p8 = $signed(press_hi[63:48]);
      p9 = $signed(p9_word);
      r.temp_centi = tmp[26:0];
      r.fine = fine;
      r.press = '0;
      r.press_ok = 1'b0;
      if (fine != 0) begin
        x1 = f64 - 64'sd128000;
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) <<< 17);
        x2 = x2 + (p4 <<< 35);
        x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
        x1 = (((64'sd1 <<< 47) + x1) * p1) >>> 33;
        if (x1 != 0) begin
          p = 64'sd1048576 - $signed({44'd0, raw_p});
          p = sdiv(((p <<< 31) - x2) * 64'sd3125, x1);
          ps = p >>> 13;
          y1 = (p9 * ps * ps) >>> 25;
          y2 = (p8 * p) >>> 19;
          p = ((p + y1 + y2) >>> 8) + (p7 <<< 4);
          r.press = p[31:0];
          r.press_ok = 1'b1;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.temp_centi !== exp_r.temp_centi) begin
        $display("%0t: temperature exp %0d got %0d", $time, exp_r.temp_centi,
                 got.temp_centi);
        errors++;
      end
      if (got.fine !== exp_r.fine) begin
        $display("%0t: fine exp %0d got %0d", $time, exp_r.fine, got.fine);
        errors++;
      end
      if (got.press !== exp_r.press) begin
        $display("%0t: pressure exp %h got %h", $time, exp_r.press, got.press);
        errors++;
      end
      if (got.press_ok !== exp_r.press_ok) begin
        $display("%0t: pressure valid exp %b got %b", $time, exp_r.press_ok,
                 got.press_ok);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] in_raw_temperature = '0;
  logic [19:0] in_raw_pressure = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [26:0] out_temperature_centi;
  logic signed [31:0] out_fine_temperature;
  logic [31:0] out_pressure_q24_8;
  logic out_pressure_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  ptc_pkg::cfg_idx_t cfg_index = ptc_pkg::CFG_TEMP_COEFFS;
  logic [63:0] cfg_data = '0;

  comp_scoreboard sb = new();
  int idle_pct = 24;
  int hold_off = 0;
  bit sink_on = 1'b0;

  always #2 clk = ~clk;

  pressure_temperature_compensation_core dut (.*);

  // Sink: random stall, with one long hold-off requested by the source.
  always @(posedge clk) begin
    if (sink_on && out_valid && !out_stall)
      sb.check_result('{out_temperature_centi, out_fine_temperature,
                        out_pressure_q24_8, out_pressure_valid});
    if (!sink_on) out_stall <= 1'b1;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(ptc_pkg::cfg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(rt, rp);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  // Typical factory calibration with each field's low byte perturbed, or a random word.
  function automatic logic [63:0] rand_word(bit typical, logic [63:0] base);
    logic [63:0] w;
    w = {$urandom, $urandom};
    return typical ? base ^ (w & 64'h00FF_00FF_00FF_00FF) : w;
  endfunction

  task automatic program_all(bit typical);
    write_reg(ptc_pkg::CFG_TEMP_COEFFS, rand_word(typical, 64'h0000_0032_6812_6C9D));
    write_reg(ptc_pkg::CFG_PRESS_LOW, rand_word(typical, 64'h2BC4_0BD0_D5D4_8E54));
    write_reg(ptc_pkg::CFG_PRESS_HIGH, rand_word(typical, 64'hC4A6_1A23_FFF9_00A9));
    write_reg(ptc_pkg::CFG_PRESS_NINE, rand_word(typical, 64'h0000_0000_0000_1770));
  endtask

  initial begin
    #200000000;
    $display("pressure_temperature_compensation_core verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_on = 1'b1;
    // All-zero coefficients: fine is zero, pressure flagged invalid.
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    program_all(1'b1);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h80000, 20'h65A00);
    send_sample(20'h7FFFF, 20'h80000);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();
    // Extreme coefficients, P1 zero gives a zero divisor.
    write_reg(ptc_pkg::CFG_TEMP_COEFFS, 64'h0000_8000_8000_FFFF);
    write_reg(ptc_pkg::CFG_PRESS_LOW, 64'h8000_8000_8000_0000);
    write_reg(ptc_pkg::CFG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(ptc_pkg::CFG_PRESS_NINE, 64'h0000_0000_0000_8000);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h12345, 20'hFFFFF);
    drain();
    write_reg(ptc_pkg::CFG_PRESS_LOW, 64'h7FFF_7FFF_7FFF_FFFF);
    write_reg(ptc_pkg::CFG_PRESS_HIGH, 64'h8000_8000_8000_8000);
    write_reg(ptc_pkg::CFG_PRESS_NINE, 64'h0000_0000_0000_7FFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h40000, 20'h40000);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      program_all(ph != 3);
      idle_pct = (ph == 2) ? 0 : 24;
      for (int i = 0; i < 90; i++) begin
        if (ph == 1 && i == 10) hold_off = 300;
        send_sample(20'($urandom), 20'($urandom));
      end
      drain();
    end
    if (sb.errors == 0)
      $display("pressure_temperature_compensation_core verification clean");
    else
      $display("pressure_temperature_compensation_core verification failed");
    $finish;
  end

endmodule
